/* rtl/cleb_pkg.sv */
package cleb_pkg;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_EOF    = 8'h04;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_PLIST  = 8'h10;
  localparam logic [7:0] KEY_KILL   = 8'h15;
  localparam logic [7:0] KEY_REBOOT = 8'h1A;
  localparam logic [7:0] KEY_DEL    = 8'h7F;

  typedef enum logic [0:0] {
    OP_KEY  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_REBOOT = 2'd1,
    CMD_PLIST  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] echo_backspaces;
    logic       line_ready;
    cmd_t       command;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_eof;
    logic       read_end;
  } res_t;

endpackage

/* rtl/cleb_ifs.sv */
interface cleb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key_code;
  logic       first_of_read;

  modport source (output valid, output op, output key_code, output first_of_read,
                  input ready);
  modport sink   (input valid, input op, input key_code, input first_of_read,
                  output ready);
endinterface

interface cleb_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] echo_backspaces;
  logic       line_ready;
  logic [1:0] command;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_eof;
  logic       read_end;

  modport source (output valid, output echo_valid, output echo_char,
                  output echo_backspaces, output line_ready, output command,
                  output read_valid, output read_data, output read_eof,
                  output read_end, input ready);
  modport sink   (input valid, input echo_valid, input echo_char,
                  input echo_backspaces, input line_ready, input command,
                  input read_valid, input read_data, input read_eof,
                  input read_end, output ready);
endinterface

/* rtl/cleb_store.sv */
module cleb_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cleb_edit.sv */
module cleb_edit import cleb_pkg::*; #(
  parameter int BUF_DEPTH = 128,
  parameter int SW        = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [7:0]    in_key,
  input  logic          in_first,
  output logic          out_valid,
  input  logic          out_ready,
  output res_t          out_res,
  output logic          mem_we,
  output logic [SW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [SW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam int IDX_MOD = 2 * BUF_DEPTH;
  localparam int IW      = $clog2(IDX_MOD);
  localparam int EW      = (IW > 8) ? IW : 8;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(IDX_MOD - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(IDX_MOD - 1) : i - IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] hi,
                                             input logic [IW-1:0] lo);
    logic [IW:0] d;
    d = {1'b0, hi} - {1'b0, lo};
    if (d[IW]) begin
      d = d + (IW+1)'(IDX_MOD);
    end
    return d[IW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] i);
    logic [IW-1:0] s;
    s = (i >= IW'(BUF_DEPTH)) ? i - IW'(BUF_DEPTH) : i;
    return s[SW-1:0];
  endfunction

  state_t        state_r, state_nxt;
  logic [IW-1:0] read_r, read_nxt;
  logic [IW-1:0] commit_r, commit_nxt;
  logic [IW-1:0] edit_r, edit_nxt;
  logic          op_r;
  logic [7:0]    key_r;
  logic          first_r;
  logic          out_valid_r;
  res_t          res_r, res_nxt;
  logic          accept;
  logic          finish;
  logic          store;
  logic [7:0]    store_char;
  logic [IW-1:0] dist_er;
  logic [IW-1:0] dist_ec;
  logic [EW-1:0] kill_cnt;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign mem_re    = accept;
  assign mem_raddr = slot_of(read_r);
  assign mem_we    = finish && store;
  assign mem_waddr = slot_of(edit_r);
  assign mem_wdata = store_char;

  assign dist_er  = idx_dist(edit_r, read_r);
  assign dist_ec  = idx_dist(edit_r, commit_r);
  assign kill_cnt = EW'(dist_ec);
  assign store_char = (key_r == KEY_CR) ? KEY_LF : key_r;

  always_comb begin
    res_nxt    = '0;
    read_nxt   = read_r;
    commit_nxt = commit_r;
    edit_nxt   = edit_r;
    store      = 1'b0;
    if (op_r == OP_KEY) begin
      unique case (key_r) inside
        KEY_REBOOT: begin
          res_nxt.command = CMD_REBOOT;
        end
        KEY_PLIST: begin
          res_nxt.command = CMD_PLIST;
        end
        KEY_KILL: begin
          edit_nxt = commit_r;
          res_nxt.echo_backspaces = (kill_cnt > EW'(255)) ? 8'd255 : kill_cnt[7:0];
        end
        KEY_BS, KEY_DEL: begin
          if (edit_r != commit_r) begin
            edit_nxt = idx_dec(edit_r);
            res_nxt.echo_backspaces = 8'd1;
          end
        end
        default: begin
          if (key_r != KEY_NUL && dist_er < IW'(BUF_DEPTH)) begin
            store              = 1'b1;
            edit_nxt           = idx_inc(edit_r);
            res_nxt.echo_valid = 1'b1;
            res_nxt.echo_char  = store_char;
            if (store_char == KEY_LF || store_char == KEY_EOF ||
                dist_er == IW'(BUF_DEPTH - 1)) begin
              commit_nxt         = idx_inc(edit_r);
              res_nxt.line_ready = 1'b1;
            end
          end
        end
      endcase
    end else begin
      if (read_r != commit_r) begin
        res_nxt.read_valid = 1'b1;
        res_nxt.read_data  = mem_rdata;
        if (mem_rdata == KEY_EOF) begin
          res_nxt.read_eof = 1'b1;
          if (first_r) begin
            read_nxt = idx_inc(read_r);
          end
        end else begin
          read_nxt = idx_inc(read_r);
          res_nxt.read_end = (mem_rdata == KEY_LF);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        read_r      <= read_nxt;
        commit_r    <= commit_nxt;
        edit_r      <= edit_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      key_r   <= in_key;
      first_r <= in_first;
    end
    if (finish) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* rtl/console_line_editor_buffer_top.sv */
// Console line editor: keyboard characters are edited into a ring of
// BUF_DEPTH bytes and committed as lines that a reader pops one byte at a
// time; every item gives exactly one result. The line memory is read in the
// cycle the item is taken and the result is formed and written back in the
// execute state, which waits while the previous result is not taken, so at
// most one item is in flight; a new one is taken when the last is through.
// A result not taken holds the block after its next item has been taken.
// The line memory is not cleared after reset and needs no start-up pass.
module console_line_editor_buffer_top import cleb_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  cleb_in_if.sink    in_ch,
  cleb_out_if.source out_ch
);

  localparam int SW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  res_t          res;

  cleb_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (SW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cleb_edit #(
    .BUF_DEPTH (BUF_DEPTH),
    .SW        (SW)
  ) u_edit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_key    (in_ch.key_code),
    .in_first  (in_ch.first_of_read),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign out_ch.echo_valid      = res.echo_valid;
  assign out_ch.echo_char       = res.echo_char;
  assign out_ch.echo_backspaces = res.echo_backspaces;
  assign out_ch.line_ready      = res.line_ready;
  assign out_ch.command         = res.command;
  assign out_ch.read_valid      = res.read_valid;
  assign out_ch.read_data       = res.read_data;
  assign out_ch.read_eof        = res.read_eof;
  assign out_ch.read_end        = res.read_end;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while another is in flight");

  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.read_valid |->
      !out_ch.echo_valid && !out_ch.line_ready && out_ch.echo_backspaces == 8'd0)
    else $error("read result mixed with edit result");

  a_eof_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.read_eof |-> out_ch.read_valid && out_ch.read_data == KEY_EOF)
    else $error("end of file flagged on wrong byte");

  a_echo_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.echo_valid |->
      out_ch.echo_char != KEY_CR && out_ch.echo_char != KEY_NUL)
    else $error("unmapped character echoed");
`endif

endmodule
